>>> src/tscp_pkg.sv
// shared constants for the text sprite command port
`default_nettype none

package tscp_pkg;

    localparam int MAX_PARAMS = 14;

    // bus access kinds
    localparam logic [1:0] KIND_STATUS_RD = 2'd0;
    localparam logic [1:0] KIND_UNIMPL_RD = 2'd1;
    localparam logic [1:0] KIND_CMD_WR    = 2'd2;
    localparam logic [1:0] KIND_PARAM_WR  = 2'd3;

    // command bytes
    localparam logic [7:0] CMD_TIMING      = 8'h10;
    localparam logic [7:0] CMD_TEXT_ON     = 8'h12;
    localparam logic [7:0] CMD_TEXT_FORMAT = 8'h14;
    localparam logic [7:0] CMD_CURSOR      = 8'h15;
    localparam logic [7:0] CMD_SPRITE_ON   = 8'h82;
    localparam logic [7:0] CMD_SPRITE_LOAD = 8'h84;

    // parameter byte counts
    localparam logic [3:0] LEN_SYNC   = 4'd14;
    localparam logic [3:0] LEN_DSPON  = 4'd3;
    localparam logic [3:0] LEN_DSPDEF = 4'd6;
    localparam logic [3:0] LEN_CURDEF = 4'd1;
    localparam logic [3:0] LEN_SPRON  = 4'd3;

    // pending command slots
    localparam logic [2:0] PEND_SYNC   = 3'd0;
    localparam logic [2:0] PEND_DSPON  = 3'd1;
    localparam logic [2:0] PEND_DSPDEF = 3'd2;
    localparam logic [2:0] PEND_CURDEF = 3'd3;
    localparam logic [2:0] PEND_SPRON  = 3'd4;

    // parameter handling modes
    localparam logic [1:0] MODE_IGNORE   = 2'd0;
    localparam logic [1:0] MODE_PARAMS   = 2'd1;
    localparam logic [1:0] MODE_SPR_OFS  = 2'd2;
    localparam logic [1:0] MODE_SPR_DATA = 2'd3;

    // memory operations
    localparam logic [1:0] MOP_NONE   = 2'd0;
    localparam logic [1:0] MOP_WRITE  = 2'd1;
    localparam logic [1:0] MOP_SET_B1 = 2'd2;
    localparam logic [1:0] MOP_CLR_B1 = 2'd3;

    localparam logic [7:0] HSYNC_15K_CODE = 8'h1c;
    localparam logic [7:0] TEXTMG_MASK    = 8'hc0;
    localparam logic [7:0] TEXTMG_CODE    = 8'h80;
    localparam logic [7:0] UNIMPL_BYTE    = 8'hff;

    localparam int TDATA_W = 120;

endpackage

`default_nettype wire

>>> src/text_sprite_command_port.sv
// command and parameter port of a text sprite display processor
//
// input beats on s_*: s_tuser carries the access kind (status read, unimplemented
// read, command write, parameter write), s_tdata the written byte.
// every input beat gives exactly one output beat on m_*: the read byte, an
// optional text memory operation and the display settings as they stand after
// that access.
// an accepted beat is registered and shows up on m_* in the cycle after it is accepted.
// throughput is one beat per cycle; the single output register is the only
// stage, so s_tready is high whenever that register is empty or being taken.
// when the receiver holds m_tready low the output beat is held and s_tready
// drops until it is taken; no beat is lost or repeated.
// reset clears busy, the parameter state, the sprite write offset and all
// display settings; the parameter store holds no meaning until a command
// writes it.
// status reads report busy at bit 2; busy stays set after a sprite define
// command until the next command write.
`default_nettype none

module text_sprite_command_port (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [7:0]                   s_tdata,  // data[7:0]
    input  wire logic [1:0]                   s_tuser,  // kind[1:0]
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // read_data[7:0], mem_addr[23:8], mem_data[31:24], display_on[32],
    // sprites_on[33], screen_lines[43:34], hsync_15khz[44], lines_changed[45],
    // text_table_page[53:46], text_format[98:54], sprite_format[113:99], zeros
    output logic [tscp_pkg::TDATA_W-1:0]      m_tdata,
    output logic [1:0]                        m_tuser   // mem_op[1:0]
);

    logic        accept;

    logic        busy_reg, busy_next;
    logic [1:0]  mode_reg, mode_next;
    logic [2:0]  pend_reg, pend_next;
    logic [3:0]  left_reg, left_next;
    logic [3:0]  idx_reg, idx_next;
    logic [15:0] ofs_reg, ofs_next;
    logic [7:0]  store_reg [tscp_pkg::MAX_PARAMS];
    logic        store_we;

    logic        dspon_reg, dspon_next;
    logic        spron_reg, spron_next;
    logic [9:0]  lines_reg, lines_next;
    logic        hsync_reg, hsync_next;
    logic [7:0]  ttp_reg, ttp_next;
    logic [44:0] tfmt_reg, tfmt_next;
    logic [14:0] sfmt_reg, sfmt_next;

    logic        out_valid_reg;
    logic [7:0]  rd_reg, rd_next;
    logic [1:0]  op_reg, op_next;
    logic [15:0] addr_reg, addr_next;
    logic [7:0]  md_reg, md_next;
    logic        chg_reg, chg_next;

    logic [7:0]  pbyte [tscp_pkg::MAX_PARAMS];
    logic [9:0]  sync_lines;
    logic        sync_h;
    logic [4:0]  curn;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // parameter bytes with the current beat merged in at its slot
    always_comb
    begin
        for (int i = 0; i < tscp_pkg::MAX_PARAMS; i++)
        begin
            pbyte[i] = (idx_reg == 4'(i)) ? s_tdata : store_reg[i];
        end
    end

    assign sync_lines = {pbyte[11][7:6], pbyte[10]};
    assign sync_h     = (pbyte[2] == tscp_pkg::HSYNC_15K_CODE);
    assign curn       = pbyte[0][7:3];

    always_comb
    begin
        busy_next  = busy_reg;
        mode_next  = mode_reg;
        pend_next  = pend_reg;
        left_next  = left_reg;
        idx_next   = idx_reg;
        ofs_next   = ofs_reg;
        store_we   = 1'b0;
        dspon_next = dspon_reg;
        spron_next = spron_reg;
        lines_next = lines_reg;
        hsync_next = hsync_reg;
        ttp_next   = ttp_reg;
        tfmt_next  = tfmt_reg;
        sfmt_next  = sfmt_reg;
        rd_next    = tscp_pkg::UNIMPL_BYTE;
        op_next    = tscp_pkg::MOP_NONE;
        addr_next  = 16'h0000;
        md_next    = 8'h00;
        chg_next   = 1'b0;

        case (s_tuser)
            tscp_pkg::KIND_STATUS_RD:
            begin
                rd_next = {5'b00000, busy_reg, 2'b00};
            end
            tscp_pkg::KIND_CMD_WR:
            begin
                idx_next  = 4'd0;
                busy_next = 1'b1;
                case (s_tdata)
                    tscp_pkg::CMD_TIMING:
                    begin
                        left_next = tscp_pkg::LEN_SYNC;
                        pend_next = tscp_pkg::PEND_SYNC;
                        mode_next = tscp_pkg::MODE_PARAMS;
                    end
                    tscp_pkg::CMD_TEXT_ON:
                    begin
                        left_next = tscp_pkg::LEN_DSPON;
                        pend_next = tscp_pkg::PEND_DSPON;
                        mode_next = tscp_pkg::MODE_PARAMS;
                    end
                    tscp_pkg::CMD_TEXT_FORMAT:
                    begin
                        left_next = tscp_pkg::LEN_DSPDEF;
                        pend_next = tscp_pkg::PEND_DSPDEF;
                        mode_next = tscp_pkg::MODE_PARAMS;
                    end
                    tscp_pkg::CMD_CURSOR:
                    begin
                        left_next = tscp_pkg::LEN_CURDEF;
                        pend_next = tscp_pkg::PEND_CURDEF;
                        mode_next = tscp_pkg::MODE_PARAMS;
                    end
                    tscp_pkg::CMD_SPRITE_ON:
                    begin
                        left_next = tscp_pkg::LEN_SPRON;
                        pend_next = tscp_pkg::PEND_SPRON;
                        mode_next = tscp_pkg::MODE_PARAMS;
                    end
                    tscp_pkg::CMD_SPRITE_LOAD:
                    begin
                        mode_next = tscp_pkg::MODE_SPR_OFS;
                    end
                    default:
                    begin
                        mode_next = tscp_pkg::MODE_IGNORE;
                        busy_next = 1'b0;
                    end
                endcase
            end
            tscp_pkg::KIND_PARAM_WR:
            begin
                case (mode_reg)
                    tscp_pkg::MODE_PARAMS:
                    begin
                        if (left_reg != 4'd0)
                        begin
                            store_we  = ({1'b0, idx_reg} < 5'(tscp_pkg::MAX_PARAMS));
                            idx_next  = idx_reg + 4'd1;
                            left_next = left_reg - 4'd1;
                            if (left_reg == 4'd1)
                            begin
                                mode_next = tscp_pkg::MODE_IGNORE;
                                case (pend_reg)
                                    tscp_pkg::PEND_SYNC:
                                    begin
                                        tfmt_next[44] = ((pbyte[0] & tscp_pkg::TEXTMG_MASK)
                                                         == tscp_pkg::TEXTMG_CODE);
                                        if (sync_lines != lines_reg || sync_h != hsync_reg)
                                        begin
                                            lines_next = sync_lines;
                                            hsync_next = sync_h;
                                            chg_next   = 1'b1;
                                        end
                                        busy_next = 1'b0;
                                    end
                                    tscp_pkg::PEND_DSPON:
                                    begin
                                        ttp_next   = pbyte[0];
                                        dspon_next = 1'b1;
                                        busy_next  = 1'b0;
                                    end
                                    tscp_pkg::PEND_DSPDEF:
                                    begin
                                        tfmt_next[15:0]  = {pbyte[1], pbyte[0]};
                                        tfmt_next[24:16] = {1'b0, pbyte[3]} + 9'd1;
                                        tfmt_next[32:25] = pbyte[4];
                                        tfmt_next[37:33] = pbyte[5][7:3];
                                        busy_next        = 1'b0;
                                    end
                                    tscp_pkg::PEND_CURDEF:
                                    begin
                                        tfmt_next[43:39] = curn;
                                        tfmt_next[38]    = pbyte[0][0];
                                        op_next   = pbyte[0][1] ? tscp_pkg::MOP_SET_B1
                                                                : tscp_pkg::MOP_CLR_B1;
                                        // page << 8 plus cursor*8+1, which stays below 256
                                        addr_next = {sfmt_reg[7:0], curn, 3'b001};
                                        busy_next = 1'b0;
                                    end
                                    tscp_pkg::PEND_SPRON:
                                    begin
                                        sfmt_next[7:0]  = pbyte[0];
                                        sfmt_next[12:8] = pbyte[2][7:3];
                                        sfmt_next[13]   = pbyte[2][1];
                                        sfmt_next[14]   = pbyte[2][0];
                                        spron_next      = 1'b1;
                                        busy_next       = 1'b0;
                                    end
                                    default:
                                    begin
                                        busy_next = busy_reg;
                                    end
                                endcase
                            end
                        end
                    end
                    tscp_pkg::MODE_SPR_OFS:
                    begin
                        ofs_next  = {8'h00, s_tdata};
                        mode_next = tscp_pkg::MODE_SPR_DATA;
                    end
                    tscp_pkg::MODE_SPR_DATA:
                    begin
                        op_next   = tscp_pkg::MOP_WRITE;
                        addr_next = {sfmt_reg[7:0], 8'h00} + ofs_reg;
                        md_next   = s_tdata;
                        ofs_next  = ofs_reg + 16'd1;
                    end
                    default:
                    begin
                        mode_next = mode_reg;
                    end
                endcase
            end
            default:
            begin
                rd_next = tscp_pkg::UNIMPL_BYTE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            mode_reg      <= tscp_pkg::MODE_IGNORE;
            pend_reg      <= tscp_pkg::PEND_SYNC;
            left_reg      <= 4'd0;
            idx_reg       <= 4'd0;
            ofs_reg       <= 16'h0000;
            dspon_reg     <= 1'b0;
            spron_reg     <= 1'b0;
            lines_reg     <= 10'd0;
            hsync_reg     <= 1'b0;
            ttp_reg       <= 8'h00;
            tfmt_reg      <= 45'd0;
            sfmt_reg      <= 15'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg  <= busy_next;
                mode_reg  <= mode_next;
                pend_reg  <= pend_next;
                left_reg  <= left_next;
                idx_reg   <= idx_next;
                ofs_reg   <= ofs_next;
                dspon_reg <= dspon_next;
                spron_reg <= spron_next;
                lines_reg <= lines_next;
                hsync_reg <= hsync_next;
                ttp_reg   <= ttp_next;
                tfmt_reg  <= tfmt_next;
                sfmt_reg  <= sfmt_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload: parameter store and output beat
    always_ff @(posedge clk)
    begin
        if (accept && store_we)
        begin
            store_reg[idx_reg] <= s_tdata;
        end
        if (accept)
        begin
            rd_reg   <= rd_next;
            op_reg   <= op_next;
            addr_reg <= addr_next;
            md_reg   <= md_next;
            chg_reg  <= chg_next;
        end
    end

    // settings registers hold the state after the beat in the output register
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = op_reg;
    assign m_tdata  = {6'd0, sfmt_reg, tfmt_reg, ttp_reg, chg_reg, hsync_reg, lines_reg,
                       spron_reg, dspon_reg, md_reg, addr_reg, rd_reg};

    a_params_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == tscp_pkg::MODE_PARAMS) |-> busy_reg)
        else $error("parameter collection without busy");

    a_sprdef_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == tscp_pkg::MODE_SPR_OFS || mode_reg == tscp_pkg::MODE_SPR_DATA)
        |-> busy_reg)
        else $error("sprite define without busy");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == tscp_pkg::MODE_PARAMS)
        |-> ({1'b0, idx_reg} < 5'(tscp_pkg::MAX_PARAMS)))
        else $error("parameter index past store");

    a_memop_read: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != tscp_pkg::MOP_NONE)
        |-> (m_tdata[7:0] == tscp_pkg::UNIMPL_BYTE && !m_tdata[45]))
        else $error("memory op on a read or with line change");

    a_sprite_stream: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode_reg == tscp_pkg::MODE_SPR_DATA && s_tuser == tscp_pkg::KIND_PARAM_WR)
        |=> (ofs_reg == $past(ofs_reg) + 16'd1 && m_tuser == tscp_pkg::MOP_WRITE))
        else $error("sprite stream offset not advanced");

endmodule

`default_nettype wire
